[hdl/iqra_pkg.sv]
`default_nettype none
package iqra_pkg;
  localparam int unsigned Ports = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PortW = $clog2(Ports);
  localparam int unsigned SlotW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned PendW = 5;

  typedef enum logic [1:0] {
    OpArrive = 2'd0,
    OpTick   = 2'd1,
    OpGrant  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KAccepted = 3'd0,
    KParked   = 3'd1,
    KForward  = 3'd2,
    KReleased = 3'd3,
    KTickDone = 3'd4,
    KUnstall  = 3'd5,
    KGrantErr = 3'd6
  } kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  in_port;
    logic [1:0]  dest_port;
    logic [31:0] packet_tag;
    logic [3:0]  accept_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  out_port;
    logic [1:0]  src_port;
    logic [31:0] tag_out;
    logic        now_stalled;
    logic [4:0]  pending;
    logic        last;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;       // capture input item
    logic       arrive;     // perform arrival
    logic       grant;      // perform grant
    logic       port_start; // begin walk on current port
    logic       step;       // read/process one queue slot
    logic       port_end;   // commit port's count, park handling
    logic       tick_end;   // update rr pointer, emit done
  } cmd_t;

  typedef struct packed {
    logic       slot_more;   // more slots on this port
    logic       port_more;   // more ports to visit
    logic       park_rel;    // parked entry will be released on port_end
    op_e        op;
  } sts_t;
endpackage
`default_nettype wire

[hdl/iqra_if.sv]
`default_nettype none
interface iqra_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/iqra_datapath.sv]
`default_nettype none
module iqra_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire iqra_pkg::cmd_t    cmd_i,
  input  wire iqra_pkg::in_item_t item_i,
  output iqra_pkg::sts_t         sts_o,
  output iqra_pkg::out_item_t    res_o,
  output logic                   res_valid_o
);
  import iqra_pkg::*;

  localparam int unsigned EntW = 32 + PortW;
  localparam int unsigned Depth = Ports * QueueDepth;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [EntW-1:0]  mem_q [Depth];
  logic [EntW-1:0]  park_q [Ports];
  logic [Ports-1:0] park_v_q;
  logic [Ports-1:0] stall_q;
  logic [CntW-1:0]  cnt_q [Ports];
  logic [PortW-1:0] rr_q, last_q, port_q, visited_q;
  logic             fwd_q;
  logic [CntW-1:0]  rd_q, keep_q;
  in_item_t         it_q;
  logic [PendW-1:0] pend_q;

  logic [PortW-1:0] ip, dp;
  logic [EntW-1:0]  rd_ent;
  logic [PortW-1:0] rd_dst;
  logic             acc;
  logic [CntW-1:0]  ip_cnt, pcnt;
  out_item_t        res_d;
  logic             res_valid_d;

  assign ip = it_q.in_port[PortW-1:0];
  assign dp = it_q.dest_port[PortW-1:0];
  assign ip_cnt = cnt_q[ip];
  assign pcnt = cnt_q[port_q];
  assign rd_ent = mem_q[{port_q, rd_q[SlotW-1:0]}];
  assign rd_dst = rd_ent[EntW-1:32];
  assign acc = (32'(rd_dst) < 32'd4) ? it_q.accept_mask[rd_dst[1:0]] : 1'b0;

  assign sts_o.slot_more = rd_q < pcnt;
  assign sts_o.port_more = (visited_q != PortW'(Ports - 1));
  assign sts_o.park_rel = park_v_q[port_q] && (keep_q < CntW'(QueueDepth));
  assign sts_o.op = op_e'(it_q.operation);

  function automatic logic [AddrW-1:0] addr(input logic [PortW-1:0] p,
                                            input logic [CntW-1:0] s);
    return {p, s[SlotW-1:0]};
  endfunction

  // queue memory and parked entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.arrive && ip_cnt < CntW'(QueueDepth)) begin
      mem_q[addr(ip, ip_cnt)] <= {dp, it_q.packet_tag};
    end else if (cmd_i.step && stall_q[rd_dst]) begin
      mem_q[addr(port_q, keep_q)] <= rd_ent;
    end else if (cmd_i.port_end && sts_o.park_rel) begin
      mem_q[addr(port_q, keep_q)] <= park_q[port_q];
    end
    if (cmd_i.arrive && ip_cnt >= CntW'(QueueDepth)) begin
      park_q[ip] <= {dp, it_q.packet_tag};
    end
    if (cmd_i.load) it_q <= item_i;
  end

  // result beat for the current command
  always_comb begin
    res_d = '0;
    res_valid_d = 1'b0;
    if (cmd_i.arrive) begin
      res_valid_d = 1'b1;
      res_d.kind = (ip_cnt >= CntW'(QueueDepth)) ? KParked : KAccepted;
      res_d.out_port = 2'(dp);
      res_d.src_port = 2'(ip);
      res_d.tag_out = it_q.packet_tag;
      res_d.last = 1'b1;
    end
    if (cmd_i.grant) begin
      res_valid_d = 1'b1;
      res_d.kind = stall_q[dp] ? KUnstall : KGrantErr;
      res_d.out_port = 2'(dp);
      res_d.last = 1'b1;
    end
    if (cmd_i.step && !stall_q[rd_dst]) begin
      res_valid_d = 1'b1;
      res_d.kind = KForward;
      res_d.out_port = 2'(rd_dst);
      res_d.src_port = 2'(port_q);
      res_d.tag_out = rd_ent[31:0];
      res_d.now_stalled = !acc;
    end
    if (cmd_i.port_end && sts_o.park_rel) begin
      res_valid_d = 1'b1;
      res_d.kind = KReleased;
      res_d.out_port = 2'(park_q[port_q][EntW-1:32]);
      res_d.src_port = 2'(port_q);
      res_d.tag_out = park_q[port_q][31:0];
    end
    if (cmd_i.tick_end) begin
      res_valid_d = 1'b1;
      res_d.kind = KTickDone;
      res_d.pending = pend_q;
      res_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      park_v_q <= '0;
      stall_q <= '0;
      for (int i = 0; i < Ports; i++) cnt_q[i] <= '0;
      rr_q <= '0;
      last_q <= '0;
      port_q <= '0;
      visited_q <= '0;
      fwd_q <= 1'b0;
      rd_q <= '0;
      keep_q <= '0;
      pend_q <= '0;
      res_valid_o <= 1'b0;
      res_o <= '0;
    end else begin
      res_valid_o <= res_valid_d;
      if (res_valid_d) res_o <= res_d;
      if (cmd_i.load) begin
        last_q <= rr_q;
        port_q <= rr_q;
        visited_q <= '0;
        pend_q <= '0;
      end
      if (cmd_i.arrive) begin
        if (ip_cnt >= CntW'(QueueDepth)) begin
          park_v_q[ip] <= 1'b1;
        end else begin
          cnt_q[ip] <= ip_cnt + 1'b1;
        end
      end
      if (cmd_i.grant) begin
        stall_q[dp] <= 1'b0;
      end
      if (cmd_i.port_start) begin
        rd_q <= '0;
        keep_q <= '0;
        fwd_q <= 1'b0;
      end
      if (cmd_i.step) begin
        rd_q <= rd_q + 1'b1;
        if (stall_q[rd_dst]) begin
          keep_q <= keep_q + 1'b1;
        end else begin
          if (!acc) stall_q[rd_dst] <= 1'b1;
          fwd_q <= 1'b1;
        end
      end
      if (cmd_i.port_end) begin
        if (sts_o.park_rel) begin
          cnt_q[port_q] <= keep_q + 1'b1;
          park_v_q[port_q] <= 1'b0;
          pend_q <= pend_q + PendW'(keep_q) + 1'b1;
        end else begin
          cnt_q[port_q] <= keep_q;
          pend_q <= pend_q + PendW'(keep_q);
        end
        if (fwd_q) last_q <= port_q;
        port_q <= port_q + 1'b1;
        visited_q <= visited_q + 1'b1;
      end
      if (cmd_i.tick_end) begin
        rr_q <= last_q + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/iqra_ctrl.sv]
`default_nettype none
module iqra_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           res_valid_i,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  input  wire iqra_pkg::sts_t sts_i,
  output iqra_pkg::cmd_t      cmd_o
);
  import iqra_pkg::*;

  typedef enum logic [2:0] {
    SIdle, SDecode, SPortStart, SStep, SPortEnd, STickEnd, SDrain
  } state_e;

  state_e state_q, state_d;
  logic   busy;

  // results leave through a one-deep output register; wait for it to drain
  assign busy = res_valid_i || (out_valid_o && !out_ready_i);
  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = SDecode;
        end
      end
      SDecode: begin
        if (!busy) begin
          unique case (sts_i.op)
            OpArrive: begin cmd_o.arrive = 1'b1; state_d = SDrain; end
            OpGrant:  begin cmd_o.grant = 1'b1; state_d = SDrain; end
            OpTick:   state_d = SPortStart;
            default:  state_d = SIdle;
          endcase
        end
      end
      SPortStart: begin
        cmd_o.port_start = 1'b1;
        state_d = SStep;
      end
      SStep: begin
        if (!busy) begin
          if (sts_i.slot_more) cmd_o.step = 1'b1;
          else state_d = SPortEnd;
        end
      end
      SPortEnd: begin
        if (!busy) begin
          cmd_o.port_end = 1'b1;
          state_d = sts_i.port_more ? SPortStart : STickEnd;
        end
      end
      STickEnd: begin
        if (!busy) begin
          cmd_o.tick_end = 1'b1;
          state_d = SDrain;
        end
      end
      SDrain: begin
        if (!busy) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_valid_i) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[hdl/input_queued_router_arbiter.sv]
`default_nettype none
// arrival and grant each produce a single result beat after acceptance
// a tick walks every port from the round-robin pointer, one step per queued entry, then emits a done beat
// throughput: one item at a time, next item accepted once the last result is taken
// output register stalls the walk while a result waits
// reset: asynchronous active low; queues empty, no stalls, no parked packets
module input_queued_router_arbiter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iqra_if.sink      in_ch,
  iqra_if.source    out_ch
);
  import iqra_pkg::*;

  cmd_t      cmd;
  sts_t      sts;
  out_item_t res;
  logic      res_valid;

  iqra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .res_valid_i (res_valid),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  iqra_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (in_ch.payload),
    .sts_o       (sts),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  assign out_ch.payload = res;
endmodule
`default_nettype wire
